>>> sv/scrolling_matrix_scanner_unit_assert.svh
// Assertion macros for the scrolling matrix scanner unit.
`ifndef SCROLLING_MATRIX_SCANNER_UNIT_ASSERT_SVH
`define SCROLLING_MATRIX_SCANNER_UNIT_ASSERT_SVH

// Same-cycle implication.
`define SMSU_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SMSU_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> sv/smsu_pkg.sv
// Shared types and constants of the scrolling matrix scanner unit.
`default_nettype none

package smsu_pkg;

    localparam int TEXT_DEPTH    = 256;
    localparam int VIS_COLS      = 32;
    localparam int ADDR_W        = $clog2(TEXT_DEPTH);
    localparam int COL_W         = $clog2(VIS_COLS);
    localparam int STEP_W        = $clog2(VIS_COLS + 1);
    localparam int PIX_W         = 8;
    localparam int TEXT_LEN_W    = 9;
    localparam int PERIOD_W      = 16;
    localparam int CFG_DATA_W    = 16;
    localparam int IN_DATA_W     = 16;
    localparam int OUT_DATA_W    = 16;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10000;

    localparam logic CFG_TEXT_COLUMNS  = 1'b0;
    localparam logic CFG_SCROLL_PERIOD = 1'b1;

    typedef enum logic [1:0] {
        OP_TICK  = 2'd0,
        OP_WRITE = 2'd1,
        OP_CLEAR = 2'd2
    } op_t;

    typedef enum logic {
        ST_IDLE   = 1'b0,
        ST_RELOAD = 1'b1
    } state_t;

    typedef struct packed {
        logic              take_tick;
        logic              take_write;
        logic              take_clear;
        logic              cfg_we;
        logic              reload_rd;
        logic              reload_wr;
        logic [STEP_W-1:0] step;
    } ctrl_cmd_t;

    typedef struct packed {
        logic reload_due;
        logic out_busy;
    } dp_status_t;

endpackage

`default_nettype wire

>>> sv/scrolling_matrix_scanner_unit.sv
// A tick or clear word appears on the output in the cycle after it is taken.
// Throughput: one word per cycle while no frame reload is due and the output is not
// stalled; a tick that reloads the frame keeps the input closed while the frame is
// refilled by 32 text memory reads over one port.
// Reset: asynchronous, active low; clears stores, scan and scroll state,
// text_columns to 0 and scroll_period to 10000.
`default_nettype none

`include "scrolling_matrix_scanner_unit_assert.svh"

module scrolling_matrix_scanner_unit (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  s_axis_tvalid,
    output logic                                       s_axis_tready,
    // [7:0] address, [15:8] column_bits
    input  wire logic [smsu_pkg::IN_DATA_W-1:0]        s_axis_tdata,
    // [1:0] op
    input  wire logic [1:0]                            s_axis_tuser,
    output logic                                       m_axis_tvalid,
    input  wire logic                                  m_axis_tready,
    // [4:0] column, [12:5] row_bits, [15:13] zero
    output logic      [smsu_pkg::OUT_DATA_W-1:0]       m_axis_tdata,
    input  wire logic                                  cfg_valid,
    output logic                                       cfg_ready,
    input  wire logic                                  cfg_index,
    input  wire logic [smsu_pkg::CFG_DATA_W-1:0]       cfg_data
);

    smsu_pkg::ctrl_cmd_t             cmd;
    smsu_pkg::dp_status_t            status;
    logic [smsu_pkg::COL_W-1:0]      out_column;
    logic [smsu_pkg::PIX_W-1:0]      out_row_bits;

    smsu_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_axis_tvalid),
        .in_op     (s_axis_tuser),
        .in_ready  (s_axis_tready),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .status    (status),
        .cmd       (cmd)
    );

    smsu_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .status         (status),
        .in_address     (s_axis_tdata[smsu_pkg::ADDR_W-1:0]),
        .in_column_bits (s_axis_tdata[smsu_pkg::ADDR_W +: smsu_pkg::PIX_W]),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .out_valid      (m_axis_tvalid),
        .out_ready      (m_axis_tready),
        .out_column     (out_column),
        .out_row_bits   (out_row_bits)
    );

    assign m_axis_tdata = smsu_pkg::OUT_DATA_W'({out_row_bits, out_column});

    `SMSU_ASSERT_NEXT(a_tick_gives_word, s_axis_tvalid && s_axis_tready && (s_axis_tuser == smsu_pkg::OP_TICK), m_axis_tvalid, "tick word missing")
    `SMSU_ASSERT_NOW(a_stall_blocks_input, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "input open while output stalled")
    `SMSU_ASSERT_NOW(a_reload_blocks_cfg, s_axis_tready, cfg_ready, "input open while config closed")

endmodule

`default_nettype wire

>>> sv/smsu_text_mem.sv
// Text column memory with per-entry valid bits for reset and clear.
`default_nettype none

module smsu_text_mem (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         clear,
    input  wire logic                         we,
    input  wire logic [smsu_pkg::ADDR_W-1:0]  waddr,
    input  wire logic [smsu_pkg::PIX_W-1:0]   wdata,
    input  wire logic                         re,
    input  wire logic [smsu_pkg::ADDR_W-1:0]  raddr,
    output logic      [smsu_pkg::PIX_W-1:0]   rdata
);

    logic [smsu_pkg::PIX_W-1:0]      mem [smsu_pkg::TEXT_DEPTH];
    logic [smsu_pkg::TEXT_DEPTH-1:0] valid_reg;
    logic [smsu_pkg::PIX_W-1:0]      rd_data_reg;
    logic                            rd_valid_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[raddr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                valid_reg <= '0;
            end
            else if (we)
            begin
                valid_reg[waddr] <= 1'b1;
            end
            if (re)
            begin
                rd_valid_reg <= valid_reg[raddr];
            end
        end
    end

    assign rdata = rd_valid_reg ? rd_data_reg : '0;

endmodule

`default_nettype wire

>>> sv/smsu_ctrl.sv
// Controller state machine: handshakes, op decode and frame reload sequencing.
`default_nettype none

module smsu_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    input  wire logic [1:0]            in_op,
    output logic                       in_ready,
    input  wire logic                  cfg_valid,
    output logic                       cfg_ready,
    input  wire smsu_pkg::dp_status_t  status,
    output smsu_pkg::ctrl_cmd_t        cmd
);

    smsu_pkg::state_t                  state_reg;
    smsu_pkg::state_t                  state_next;
    logic [smsu_pkg::STEP_W-1:0]       step_reg;
    logic [smsu_pkg::STEP_W-1:0]       step_next;
    logic                              take;
    logic                              step_last;

    assign step_last = (step_reg == smsu_pkg::STEP_W'(smsu_pkg::VIS_COLS));
    assign take      = in_valid && in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= smsu_pkg::ST_IDLE;
            step_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            step_reg  <= step_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        unique case (state_reg)
            smsu_pkg::ST_IDLE:
            begin
                step_next = '0;
                if (take && (in_op == smsu_pkg::OP_TICK) && status.reload_due)
                begin
                    state_next = smsu_pkg::ST_RELOAD;
                end
            end
            smsu_pkg::ST_RELOAD:
            begin
                step_next = step_reg + 1'b1;
                if (step_last)
                begin
                    state_next = smsu_pkg::ST_IDLE;
                    step_next  = '0;
                end
            end
            default:
            begin
                state_next = smsu_pkg::ST_IDLE;
                step_next  = '0;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = 1'b0;
        cfg_ready      = 1'b0;
        cmd            = '0;
        cmd.step       = step_reg;
        unique case (state_reg)
            smsu_pkg::ST_IDLE:
            begin
                in_ready       = !status.out_busy;
                cfg_ready      = 1'b1;
                cmd.cfg_we     = cfg_valid;
                cmd.take_tick  = take && (in_op == smsu_pkg::OP_TICK);
                cmd.take_write = take && (in_op == smsu_pkg::OP_WRITE);
                cmd.take_clear = take && (in_op == smsu_pkg::OP_CLEAR);
            end
            smsu_pkg::ST_RELOAD:
            begin
                cmd.reload_rd = !step_last;
                cmd.reload_wr = (step_reg != '0);
            end
            default:
            begin
                in_ready = 1'b0;
            end
        endcase
    end

endmodule

`default_nettype wire

>>> sv/smsu_dp.sv
// Datapath: scan and scroll registers, frame, text memory and output word.
`default_nettype none

module smsu_dp (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire smsu_pkg::ctrl_cmd_t             cmd,
    output smsu_pkg::dp_status_t                 status,
    input  wire logic [smsu_pkg::ADDR_W-1:0]     in_address,
    input  wire logic [smsu_pkg::PIX_W-1:0]      in_column_bits,
    input  wire logic                            cfg_index,
    input  wire logic [smsu_pkg::CFG_DATA_W-1:0] cfg_data,
    output logic                                 out_valid,
    input  wire logic                            out_ready,
    output logic      [smsu_pkg::COL_W-1:0]      out_column,
    output logic      [smsu_pkg::PIX_W-1:0]      out_row_bits
);

    logic [smsu_pkg::PIX_W-1:0]      frame_reg [smsu_pkg::VIS_COLS];
    logic [smsu_pkg::COL_W-1:0]      scan_index_reg;
    logic [smsu_pkg::PERIOD_W-1:0]   tick_count_reg;
    logic [smsu_pkg::ADDR_W-1:0]     scroll_pos_reg;
    logic                            moving_back_reg;
    logic [smsu_pkg::ADDR_W-1:0]     base_reg;
    logic [smsu_pkg::TEXT_LEN_W-1:0] text_columns_reg;
    logic [smsu_pkg::PERIOD_W-1:0]   scroll_period_reg;
    logic                            out_valid_reg;
    logic [smsu_pkg::COL_W-1:0]      out_column_reg;
    logic [smsu_pkg::PIX_W-1:0]      out_row_reg;

    logic                            long_text;
    logic [smsu_pkg::ADDR_W-1:0]     pos_step;
    logic [smsu_pkg::TEXT_LEN_W-1:0] span;
    logic                            flip;
    logic [smsu_pkg::ADDR_W-1:0]     rd_addr;
    logic [smsu_pkg::COL_W-1:0]      wr_index;
    logic [smsu_pkg::PIX_W-1:0]      mem_rdata;

    assign long_text = text_columns_reg > smsu_pkg::TEXT_LEN_W'(smsu_pkg::VIS_COLS);
    assign pos_step  = moving_back_reg ? scroll_pos_reg - 1'b1 : scroll_pos_reg + 1'b1;
    assign span      = text_columns_reg - smsu_pkg::TEXT_LEN_W'(smsu_pkg::VIS_COLS);
    assign flip      = ({1'b0, pos_step} >= span) || (pos_step == '0);
    assign rd_addr   = base_reg + smsu_pkg::ADDR_W'(cmd.step[smsu_pkg::COL_W-1:0]);
    assign wr_index  = cmd.step[smsu_pkg::COL_W-1:0] - 1'b1;

    assign status.reload_due = tick_count_reg >= scroll_period_reg;
    assign status.out_busy   = out_valid_reg && !out_ready;

    smsu_text_mem u_text_mem (
        .clk   (clk),
        .rst_n (rst_n),
        .clear (cmd.take_clear),
        .we    (cmd.take_write),
        .waddr (in_address),
        .wdata (in_column_bits),
        .re    (cmd.reload_rd),
        .raddr (rd_addr),
        .rdata (mem_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < smsu_pkg::VIS_COLS; i++)
            begin
                frame_reg[i] <= '0;
            end
            scan_index_reg    <= '0;
            tick_count_reg    <= '0;
            scroll_pos_reg    <= '0;
            moving_back_reg   <= 1'b0;
            base_reg          <= '0;
            text_columns_reg  <= '0;
            scroll_period_reg <= smsu_pkg::PERIOD_RESET;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.cfg_we)
            begin
                unique case (cfg_index)
                    smsu_pkg::CFG_TEXT_COLUMNS:
                        text_columns_reg <= cfg_data[smsu_pkg::TEXT_LEN_W-1:0];
                    smsu_pkg::CFG_SCROLL_PERIOD:
                        scroll_period_reg <= cfg_data[smsu_pkg::PERIOD_W-1:0];
                    default:
                        text_columns_reg <= text_columns_reg;
                endcase
            end

            if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end

            if (cmd.take_tick)
            begin
                out_valid_reg  <= 1'b1;
                scan_index_reg <= scan_index_reg + 1'b1;
                if (status.reload_due)
                begin
                    base_reg <= scroll_pos_reg;
                    if (long_text)
                    begin
                        scroll_pos_reg  <= pos_step;
                        moving_back_reg <= moving_back_reg ^ flip;
                        tick_count_reg  <= smsu_pkg::PERIOD_W'(1);
                    end
                    else
                    begin
                        scroll_pos_reg <= '0;
                        tick_count_reg <= '0;
                    end
                end
                else
                begin
                    tick_count_reg <= tick_count_reg + 1'b1;
                end
            end

            if (cmd.take_clear)
            begin
                out_valid_reg   <= 1'b1;
                scroll_pos_reg  <= '0;
                moving_back_reg <= 1'b0;
                for (int i = 0; i < smsu_pkg::VIS_COLS; i++)
                begin
                    frame_reg[i] <= '0;
                end
            end

            if (cmd.reload_wr)
            begin
                frame_reg[wr_index] <= mem_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_tick)
        begin
            out_column_reg <= scan_index_reg;
            out_row_reg    <= frame_reg[scan_index_reg];
        end
        else if (cmd.take_clear)
        begin
            out_column_reg <= '0;
            out_row_reg    <= '0;
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_column   = out_column_reg;
    assign out_row_bits = out_row_reg;

endmodule

`default_nettype wire

>>> dv/tb_scrolling_matrix_scanner_unit.sv
// Testbench for the scrolling matrix scanner: random and directed words, checked per word.
`default_nettype none

module tb_scrolling_matrix_scanner_unit;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int DRAIN_CYCLES = 40;

    localparam logic [1:0] OP_UNUSED = 2'd3;

    typedef struct packed {
        logic [smsu_pkg::COL_W-1:0] column;
        logic [smsu_pkg::PIX_W-1:0] row_bits;
    } scan_word_t;

    logic                            clk = 1'b0;
    logic                            rst_n = 1'b0;
    logic                            s_axis_tvalid = 1'b0;
    logic                            s_axis_tready;
    logic [smsu_pkg::IN_DATA_W-1:0]  s_axis_tdata = '0;
    logic [1:0]                      s_axis_tuser = smsu_pkg::OP_TICK;
    logic                            m_axis_tvalid;
    logic                            m_axis_tready = 1'b0;
    logic [smsu_pkg::OUT_DATA_W-1:0] m_axis_tdata;
    logic                            cfg_valid = 1'b0;
    logic                            cfg_ready;
    logic                            cfg_index = smsu_pkg::CFG_TEXT_COLUMNS;
    logic [smsu_pkg::CFG_DATA_W-1:0] cfg_data = '0;

    // expected scanner state
    logic [smsu_pkg::PIX_W-1:0]      text_img [smsu_pkg::TEXT_DEPTH];
    logic [smsu_pkg::PIX_W-1:0]      frame_img [smsu_pkg::VIS_COLS];
    logic [smsu_pkg::COL_W-1:0]      scan_col = '0;
    logic [smsu_pkg::PERIOD_W-1:0]   tick_cnt = '0;
    logic [smsu_pkg::ADDR_W-1:0]     scroll_pos = '0;
    logic                            moving_back = 1'b0;
    logic [smsu_pkg::TEXT_LEN_W-1:0] text_len = '0;
    logic [smsu_pkg::PERIOD_W-1:0]   period = smsu_pkg::PERIOD_RESET;

    scan_word_t            pending_scan_words [$];
    int                    mismatch_cnt = 0;
    int                    cycle_cnt = 0;
    int                    stall_until = 0;
    int                    send_idle_pct = 17;
    int                    recv_idle_pct = 61;

    scrolling_matrix_scanner_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        foreach (text_img[i])
            text_img[i] = '0;
        foreach (frame_img[i])
            frame_img[i] = '0;
    end

    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (cycle_cnt < stall_until)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
    end

    task automatic predict_scan_word(input logic [1:0] op,
                                     input logic [smsu_pkg::ADDR_W-1:0] addr,
                                     input logic [smsu_pkg::PIX_W-1:0] bits);
        scan_word_t w;
        int i;
        case (op)
            smsu_pkg::OP_TICK:
            begin
                w.column = scan_col;
                w.row_bits = frame_img[scan_col];
                pending_scan_words.push_back(w);
                scan_col = scan_col + 1'b1;
                if (tick_cnt >= period)
                begin
                    for (i = 0; i < smsu_pkg::VIS_COLS; i++)
                        frame_img[i] = text_img[smsu_pkg::ADDR_W'(scroll_pos + i)];
                    tick_cnt = '0;
                    if (text_len <= smsu_pkg::VIS_COLS)
                        scroll_pos = '0;
                    else
                    begin
                        scroll_pos = moving_back ? scroll_pos - 1'b1 : scroll_pos + 1'b1;
                        if (int'(scroll_pos) >= int'(text_len) - smsu_pkg::VIS_COLS
                            || scroll_pos == 0)
                            moving_back = !moving_back;
                        tick_cnt = smsu_pkg::PERIOD_W'(1);
                    end
                end
                else
                    tick_cnt = tick_cnt + 1'b1;
            end
            smsu_pkg::OP_WRITE:
                text_img[addr] = bits;
            smsu_pkg::OP_CLEAR:
            begin
                foreach (text_img[k])
                    text_img[k] = '0;
                foreach (frame_img[k])
                    frame_img[k] = '0;
                scroll_pos = '0;
                moving_back = 1'b0;
                pending_scan_words.push_back('0);
            end
            default:
                ;
        endcase
    endtask

    always @(posedge clk)
    begin
        scan_word_t want;
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (pending_scan_words.size() == 0)
                begin
                    mismatch_cnt++;
                    if (mismatch_cnt <= 10)
                        $display("unexpected word: column %0d row_bits %02h",
                                 m_axis_tdata[4:0], m_axis_tdata[12:5]);
                end
                else
                begin
                    want = pending_scan_words.pop_front();
                    if (m_axis_tdata[4:0] !== want.column
                        || m_axis_tdata[12:5] !== want.row_bits)
                    begin
                        mismatch_cnt++;
                        if (mismatch_cnt <= 10)
                            $display("mismatch: column exp %0d got %0d, row_bits exp %02h got %02h",
                                     want.column, m_axis_tdata[4:0],
                                     want.row_bits, m_axis_tdata[12:5]);
                    end
                end
            end
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == smsu_pkg::CFG_TEXT_COLUMNS)
                    text_len = cfg_data[smsu_pkg::TEXT_LEN_W-1:0];
                else
                    period = cfg_data[smsu_pkg::PERIOD_W-1:0];
            end
            if (s_axis_tvalid && s_axis_tready)
                predict_scan_word(s_axis_tuser, s_axis_tdata[7:0], s_axis_tdata[15:8]);
        end
    end

    task automatic send_word(input logic [1:0] op, input logic [smsu_pkg::ADDR_W-1:0] addr,
                             input logic [smsu_pkg::PIX_W-1:0] bits);
        while ($urandom_range(99) < send_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= op;
        s_axis_tdata <= {bits, addr};
        do
            @(posedge clk);
        while (!s_axis_tready);
    endtask

    task automatic wait_drained();
        s_axis_tvalid <= 1'b0;
        while (pending_scan_words.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [smsu_pkg::CFG_DATA_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    task automatic send_random_word();
        int r;
        logic [smsu_pkg::ADDR_W-1:0] a;
        logic [smsu_pkg::PIX_W-1:0]  b;
        r = $urandom_range(99);
        a = smsu_pkg::ADDR_W'($urandom_range(255));
        b = smsu_pkg::PIX_W'($urandom_range(255));
        if (r < 55)
            send_word(smsu_pkg::OP_TICK, a, b);
        else if (r < 95)
            send_word(smsu_pkg::OP_WRITE, a, b);
        else if (r < 97)
            send_word(smsu_pkg::OP_CLEAR, a, b);
        else
            send_word(OP_UNUSED, a, b);
    endtask

    task automatic test_directed_edges();
        int i;
        send_word(smsu_pkg::OP_TICK, 8'h00, 8'h00);
        send_word(smsu_pkg::OP_CLEAR, 8'hFF, 8'hFF);
        send_word(smsu_pkg::OP_WRITE, 8'h00, 8'hFF);
        send_word(smsu_pkg::OP_WRITE, 8'hFF, 8'h00);
        send_word(smsu_pkg::OP_WRITE, 8'h01, 8'hAA);
        send_word(smsu_pkg::OP_WRITE, 8'h20, 8'h55);
        send_word(OP_UNUSED, 8'hFF, 8'hFF);
        send_word(smsu_pkg::OP_TICK, 8'hFF, 8'hFF);
        // zero period: reload on every tick, text one column wider than the display
        write_reg(smsu_pkg::CFG_SCROLL_PERIOD, 16'd0);
        write_reg(smsu_pkg::CFG_TEXT_COLUMNS, 16'd33);
        for (i = 0; i < 6; i++)
            send_word(smsu_pkg::OP_TICK, 8'h00, 8'h00);
        // oversized text length
        write_reg(smsu_pkg::CFG_TEXT_COLUMNS, 16'h01FF);
        for (i = 0; i < 4; i++)
            send_word(smsu_pkg::OP_TICK, 8'h00, 8'h00);
        send_word(smsu_pkg::OP_CLEAR, 8'h00, 8'h00);
        send_word(smsu_pkg::OP_TICK, 8'h00, 8'h00);
    endtask

    task automatic test_scroll_phase(input int cols, input int per, input int count);
        write_reg(smsu_pkg::CFG_TEXT_COLUMNS, smsu_pkg::CFG_DATA_W'(cols));
        write_reg(smsu_pkg::CFG_SCROLL_PERIOD, smsu_pkg::CFG_DATA_W'(per));
        repeat (count) send_random_word();
    endtask

    task automatic test_output_stall();
        logic [smsu_pkg::ADDR_W-1:0] a;
        logic [smsu_pkg::PIX_W-1:0]  b;
        write_reg(smsu_pkg::CFG_TEXT_COLUMNS, 16'd40);
        write_reg(smsu_pkg::CFG_SCROLL_PERIOD, 16'hFFFF);
        stall_until = cycle_cnt + 300;
        repeat (80)
        begin
            a = smsu_pkg::ADDR_W'($urandom_range(255));
            b = smsu_pkg::PIX_W'($urandom_range(255));
            send_word(smsu_pkg::OP_TICK, a, b);
        end
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_edges();
        test_scroll_phase(256, 1, 200);
        test_scroll_phase(33, 0, 150);
        test_scroll_phase(511, 2, 150);

        send_idle_pct = 61;
        recv_idle_pct = 17;
        test_scroll_phase(0, 3, 150);
        test_scroll_phase(32, 1, 150);
        test_scroll_phase(100, 0, 200);
        test_output_stall();

        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_scroll_phase(256, 5, 200);
        test_scroll_phase(34, 1, 150);

        wait_drained();
        if (mismatch_cnt == 0 && pending_scan_words.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

`default_nettype wire
